// ===== sv/b32_pkg.sv =====
// shared types, constants and symbol mapping functions for the base32 stream codec
package b32_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic       DIR_ENCODE      = 1'b0;
	localparam logic       DIR_DECODE      = 1'b1;
	localparam logic [7:0] REG_DIRECTION   = 8'd0;
	localparam logic [7:0] REG_MAX_SYMBOLS = 8'd1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       message_end;
		logic       truncated;
	} out_item_t;

	// full set: chunk is complete; otherwise a bare end-of-message marker
	typedef struct packed {
		logic [39:0] chunk;
		logic        full;
		logic        last;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_beat_t;

	function automatic logic [7:0] symbol_of(input logic [4:0] v);
		logic [7:0] r;
		if (v < 5'd26) begin
			r = 8'd65 + {3'd0, v};
		end else begin
			r = 8'd50 + {3'd0, v} - 8'd26;
		end
		return r;
	endfunction

	// anything outside the alphabet, lower case too, maps to zero
	function automatic logic [4:0] value_of(input logic [7:0] c);
		logic [7:0] r;
		r = 8'd0;
		if (c inside {[8'd65:8'd90]}) begin
			r = c - 8'd65;
		end else if (c inside {[8'd50:8'd55]}) begin
			r = c - 8'd50 + 8'd26;
		end
		return r[4:0];
	endfunction

endpackage

// ===== sv/b32_front.sv =====
// front end: takes input beats, packs them into 40-bit chunks and queues them
module b32_front import b32_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     dir,
	input  logic     msg_clear,
	input  logic     q_full,
	output q_beat_t  push
);

	logic [39:0] chunk_q;
	logic [2:0]  fill_q;
	logic [39:0] chunk_nxt;
	logic        done;
	logic        accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		if (dir == DIR_ENCODE) begin
			chunk_nxt = {chunk_q[31:0], in_data.in_byte};
			done      = (fill_q == 3'd4);
		end else begin
			chunk_nxt = {chunk_q[34:0], value_of(in_data.in_byte)};
			done      = (fill_q == 3'd7);
		end
		push.valid       = accept && (done || in_data.in_last);
		push.entry.chunk = chunk_nxt;
		push.entry.full  = done;
		push.entry.last  = in_data.in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			fill_q  <= '0;
		end else if (msg_clear) begin
			chunk_q <= '0;
			fill_q  <= '0;
		end else if (accept) begin
			if (done || in_data.in_last) begin
				chunk_q <= '0;
				fill_q  <= '0;
			end else begin
				chunk_q <= chunk_nxt;
				fill_q  <= fill_q + 3'd1;
			end
		end
	end

endmodule

// ===== sv/b32_queue.sv =====
// short chunk queue between front and back ends
module b32_queue import b32_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_beat_t push,
	input  logic    pop,
	output q_beat_t head,
	output logic    full
);

	q_entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/b32_back.sv =====
// back end: splits queued chunks into symbols or bytes, one output beat a cycle while out_stall is low
module b32_back import b32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        dir,
	input  logic [15:0] max_symbols,
	input  logic        msg_clear,
	input  q_beat_t     head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [2:0]  k_q;
	logic [15:0] emitted_q;
	logic        limit_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [4:0]  syms [8];
	logic [7:0]  bytes [5];
	logic        adv;
	logic        emit;
	logic        fin;
	logic        clr;
	logic [2:0]  k_n;
	logic [15:0] em_n;
	logic [15:0] cnt_inc;
	logic        lim_n;
	out_item_t   out_n;

	assign adv       = !out_valid_q || !out_stall;
	assign cnt_inc   = emitted_q + 16'd1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			syms[i] = head.entry.chunk[39 - 5 * i -: 5];
		end
		for (int i = 0; i < 5; i++) begin
			bytes[i] = head.entry.chunk[39 - 8 * i -: 8];
		end
	end

	always_comb begin
		pop   = 1'b0;
		emit  = 1'b0;
		fin   = 1'b0;
		clr   = 1'b0;
		k_n   = k_q;
		em_n  = emitted_q;
		lim_n = limit_q;
		out_n = '0;
		if (head.valid && adv) begin
			if (!head.entry.full) begin
				pop = 1'b1;
				clr = head.entry.last;
			end else if (dir == DIR_ENCODE) begin
				if (emitted_q < max_symbols) begin
					emit              = 1'b1;
					em_n              = cnt_inc;
					lim_n             = limit_q | (cnt_inc == max_symbols);
					// the beat is the last one of the chunk at the eighth symbol, or if the limit stops the rest
					fin               = (k_q == 3'd7) || (cnt_inc == max_symbols);
					out_n.out_byte    = symbol_of(syms[k_q]);
					out_n.run_last    = fin;
					out_n.message_end = fin && head.entry.last;
					out_n.truncated   = lim_n;
				end else begin
					// rest of the chunk is suppressed in one go
					lim_n = 1'b1;
					fin   = 1'b1;
				end
				if (fin) begin
					pop = 1'b1;
					k_n = '0;
					clr = head.entry.last;
				end else begin
					k_n = k_q + 3'd1;
				end
			end else begin
				emit              = 1'b1;
				fin               = (k_q == 3'd4);
				out_n.out_byte    = bytes[k_q];
				out_n.run_last    = fin;
				out_n.message_end = fin && head.entry.last;
				if (fin) begin
					pop = 1'b1;
					k_n = '0;
					clr = head.entry.last;
				end else begin
					k_n = k_q + 3'd1;
				end
			end
			if (clr) begin
				em_n  = '0;
				lim_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			emitted_q   <= '0;
			limit_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (msg_clear) begin
				k_q       <= '0;
				emitted_q <= '0;
				limit_q   <= 1'b0;
			end else begin
				k_q       <= k_n;
				emitted_q <= em_n;
				limit_q   <= lim_n;
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_q <= out_n;
		end
	end

endmodule

// ===== sv/base32_stream_codec.sv =====
// top level of the unpadded base32 stream encoder / decoder
//
// in_* carries one byte per beat with an end-of-message flag; out_* carries
// one symbol (encode) or one byte (decode) per beat. the cfg channel writes
// register 0 (direction, 0 encode, 1 decode; clears any partial message) and
// register 1 (encode symbol limit per message); cfg_ready is always high and
// writes are meant to happen only while the block is idle.
// the front end packs beats into 40-bit chunks and hands each finished chunk
// to a four-entry queue; the back end turns a chunk into 8 symbols or 5 bytes
// at one output beat per cycle while out_stall is low. the first result of a
// chunk passes through the queue and then the output register to out_valid.
// decode takes one input beat per cycle while out_stall stays low; in encode
// the back end, at 8 output symbols per 5 input bytes, sets the pace.
// in_stall rises only when the queue is full. a stalled output beat holds in
// the output register while the queue keeps absorbing input.
// reset clears the message state, selects encode and sets the limit to 65535.
module base32_stream_codec import b32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        dir_q;
	logic [15:0] max_symbols_q;
	logic        msg_clear;
	logic        q_full;
	logic        pop;
	q_beat_t     push;
	q_beat_t     head;

	assign cfg_ready = 1'b1;
	assign msg_clear = cfg_valid && (cfg_index == REG_DIRECTION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q         <= DIR_ENCODE;
			max_symbols_q <= 16'hFFFF;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DIRECTION) begin
				dir_q <= cfg_data[0];
			end else if (cfg_index == REG_MAX_SYMBOLS) begin
				max_symbols_q <= cfg_data;
			end
		end
	end

	b32_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.dir       (dir_q),
		.msg_clear (msg_clear),
		.q_full    (q_full),
		.push      (push)
	);

	b32_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	b32_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.dir         (dir_q),
		.max_symbols (max_symbols_q),
		.msg_clear   (msg_clear),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule
